### hw/rtl/ccs_pkg.sv
// Shared types, constants and calendar helpers for the calendar clock.
// No dependencies; imported by ccs_conv and calendar_clock_with_epoch_sync_top.
package ccs_pkg;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_DATE  = 2'd1,
        OP_SET_EPOCH = 2'd2,
        OP_READ      = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MIN,
        PH_SEC,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date;

    typedef struct packed {
        logic start;
        logic to_date;   // 1: epoch seconds -> date, 0: date -> epoch seconds
    } t_conv_req;

    localparam logic [11:0] EpochYear      = 12'd1970;
    localparam logic [11:0] LastSetYear    = 12'd2105;
    localparam logic [31:0] SecPerDay      = 32'd86400;
    localparam logic [31:0] SecPerHour     = 32'd3600;
    localparam logic [31:0] SecPerMin      = 32'd60;
    localparam logic [31:0] SecPerYear     = 32'd31536000;
    localparam logic [31:0] SecPerLeapYear = 32'd31622400;
    localparam logic [31:0] EpochLimit     = 32'd4291747200;  // 2106-01-01 00:00:00
    localparam logic [9:0]  TpsReset       = 10'd100;

    localparam t_date DateReset = '{year: 12'd1970, month: 4'd1, day: 5'd1,
                                    hour: 5'd0, minute: 6'd0, second: 6'd0};

    // Exact for the years the clock can hold (1970..2106): 2000 is leap, 2100 is not.
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:                      n = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

### hw/rtl/ccs_conv.sv
// Iterative date <-> epoch-seconds converter: one shared 33-bit add/subtract unit.
// Depends on ccs_pkg.
module ccs_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccs_pkg::t_conv_req i_req,
    input  logic [31:0]       i_epoch,
    input  ccs_pkg::t_date    i_date,
    output logic              o_done,
    output logic [31:0]       o_epoch,
    output ccs_pkg::t_date    o_date
);
    import ccs_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_to_date;
    logic [31:0] r_acc;
    logic [31:0] r_ein;
    t_date       r_cnt;
    t_date       r_tgt;

    logic [31:0] step;
    logic [32:0] sum;
    logic        carry;
    logic        cont;

    // step size for the current phase
    always_comb begin
        case (r_phase)
            PH_YEAR:  step = is_leap(r_cnt.year) ? SecPerLeapYear : SecPerYear;
            PH_MONTH: step = 32'(month_len(r_cnt.year, r_cnt.month)) * SecPerDay;
            PH_DAY:   step = SecPerDay;
            PH_HOUR:  step = SecPerHour;
            PH_MIN:   step = SecPerMin;
            PH_SEC:   step = {26'd0, r_tgt.second};
            default:  step = '0;
        endcase
    end

    // shared unit: subtract in to_date mode (carry = acc >= step), add otherwise
    assign sum   = {1'b0, r_acc} + {1'b0, (r_to_date ? ~step : step)} + {32'd0, r_to_date};
    assign carry = sum[32];

    always_comb begin
        case (r_phase)
            PH_YEAR:  cont = r_to_date ? carry : (r_cnt.year < r_tgt.year);
            PH_MONTH: cont = r_to_date ? (carry && (r_cnt.month < 4'd12))
                                       : (r_cnt.month < r_tgt.month);
            PH_DAY:   cont = r_to_date ? carry : (r_cnt.day < r_tgt.day);
            PH_HOUR:  cont = r_to_date ? carry : (r_cnt.hour < r_tgt.hour);
            PH_MIN:   cont = r_to_date ? carry : (r_cnt.minute < r_tgt.minute);
            default:  cont = 1'b0;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_IDLE:  n_phase = i_req.start ? PH_YEAR : PH_IDLE;
            PH_YEAR:  n_phase = cont ? PH_YEAR  : PH_MONTH;
            PH_MONTH: n_phase = cont ? PH_MONTH : PH_DAY;
            PH_DAY:   n_phase = cont ? PH_DAY   : PH_HOUR;
            PH_HOUR:  n_phase = cont ? PH_HOUR  : PH_MIN;
            PH_MIN:   n_phase = cont ? PH_MIN   : PH_SEC;
            PH_SEC:   n_phase = PH_DONE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && (r_phase == PH_IDLE)) begin
            r_to_date <= i_req.to_date;
            r_acc     <= i_req.to_date ? i_epoch : 32'd0;
            r_ein     <= i_epoch;
            r_tgt     <= i_date;
            r_cnt     <= DateReset;
        end else begin
            case (r_phase)
                PH_YEAR: begin
                    if (cont) begin
                        r_acc      <= sum[31:0];
                        r_cnt.year <= r_cnt.year + 12'd1;
                    end
                end
                PH_MONTH: begin
                    if (cont) begin
                        r_acc       <= sum[31:0];
                        r_cnt.month <= r_cnt.month + 4'd1;
                    end
                end
                PH_DAY: begin
                    if (cont) begin
                        r_acc     <= sum[31:0];
                        r_cnt.day <= r_cnt.day + 5'd1;
                    end
                end
                PH_HOUR: begin
                    if (cont) begin
                        r_acc      <= sum[31:0];
                        r_cnt.hour <= r_cnt.hour + 5'd1;
                    end
                end
                PH_MIN: begin
                    if (cont) begin
                        r_acc        <= sum[31:0];
                        r_cnt.minute <= r_cnt.minute + 6'd1;
                    end
                end
                PH_SEC: begin
                    if (!r_to_date) begin
                        r_acc <= sum[31:0];
                    end
                    r_cnt.second <= r_to_date ? r_acc[5:0] : r_tgt.second;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done  = (r_phase == PH_DONE);
    // epoch -> date leaves only the remainder in the accumulator; report the input
    assign o_epoch = r_to_date ? r_ein : r_acc;
    assign o_date  = r_cnt;

    a_done_after_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_phase == PH_SEC))
        else $error("conv done without seconds phase");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_phase == PH_IDLE))
        else $error("conv started while busy");

    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_to_date) |-> (r_cnt.hour < 5'd24 && r_cnt.minute < 6'd60
                                   && r_cnt.month >= 4'd1 && r_cnt.month <= 4'd12))
        else $error("conv produced out-of-range date");

endmodule

### hw/rtl/calendar_clock_with_epoch_sync_top.sv
// Calendar clock top: a tick or read fills the result register in the cycle after its transfer.
// Set date / set epoch run the shared converter, which steps through years, months,
// days, hours and minutes one unit at a time; invalid sets answer like tick/read.
// The converter has a single add/subtract unit and handles one item at a time.
// Synchronous active-low reset: 1970-01-01 00:00:00, epoch 0, unsynced, 100 ticks/s.
// Depends on ccs_pkg and ccs_conv.
module calendar_clock_with_epoch_sync_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_set_year,
    input  logic [3:0]  i_set_month,
    input  logic [4:0]  i_set_day,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    input  logic [5:0]  i_set_second,
    input  logic [31:0] i_epoch_in,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [9:0]  o_subtick_out,
    output logic [31:0] o_epoch_out,
    output logic        o_synced_out,
    output logic        o_error_out
);
    import ccs_pkg::*;

    t_state      r_state, n_state;
    logic [9:0]  r_tps, n_tps;
    t_date       r_cur, n_cur;
    logic [9:0]  r_sub, n_sub;
    logic [31:0] r_epoch, n_epoch;
    logic        r_synced, n_synced;

    // result register; a new transfer is taken, outside conversion, once it is free or draining
    logic        r_o_valid, n_o_valid;
    t_date       r_out_date, n_out_date;
    logic [9:0]  r_out_sub, n_out_sub;
    logic [31:0] r_out_epoch, n_out_epoch;
    logic        r_out_synced, n_out_synced;
    logic        r_out_err, n_out_err;

    logic        accept;
    t_opcode     op;
    t_date       in_date;
    logic        date_ok;
    logic        epoch_bad;
    t_conv_req   conv_req;
    logic        conv_done;
    logic [31:0] conv_epoch;
    t_date       conv_date;

    // tick path
    logic [9:0]  rate;
    logic [10:0] sub_inc;
    logic        wrap;
    logic [31:0] ep1;
    t_date       roll;

    assign op      = t_opcode'(i_opcode);
    assign accept  = i_valid && o_ready;
    assign in_date = '{year: i_set_year, month: i_set_month, day: i_set_day,
                       hour: i_set_hour, minute: i_set_minute, second: i_set_second};

    // set-date check; an out-of-range month fails the month bounds whatever month_len returns
    assign date_ok = (i_set_year >= EpochYear) && (i_set_year <= LastSetYear)
                  && (i_set_month >= 4'd1) && (i_set_month <= 4'd12)
                  && (i_set_hour < 5'd24) && (i_set_minute < 6'd60)
                  && (i_set_second < 6'd60) && (i_set_day >= 5'd1)
                  && (i_set_day <= month_len(i_set_year, i_set_month));
    // anything in 2106 or later is refused
    assign epoch_bad = (i_epoch_in >= EpochLimit);

    // ---- FSM next state ----
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = conv_req.start ? ST_CONV : ST_IDLE;
            ST_CONV: n_state = conv_done ? ST_IDLE : ST_CONV;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- FSM outputs ----
    always_comb begin
        case (r_state)
            ST_IDLE: o_ready = !r_o_valid || i_ready;
            default: o_ready = 1'b0;
        endcase
        conv_req.start   = accept && (((op == OP_SET_DATE) && date_ok)
                                   || ((op == OP_SET_EPOCH) && !epoch_bad));
        conv_req.to_date = (op == OP_SET_EPOCH);
    end

    // ---- one-second carry through the calendar ----
    assign rate    = (r_tps == 10'd0) ? 10'd1 : r_tps;
    assign sub_inc = {1'b0, r_sub} + 11'd1;
    assign wrap    = (sub_inc >= {1'b0, rate});   // also catches a lowered rate
    assign ep1     = r_epoch + 32'd1;

    always_comb begin
        roll = r_cur;
        if (ep1 == 32'd0) begin
            roll = DateReset;   // epoch counter overflow restarts the calendar
        end else if (r_cur.second != 6'd59) begin
            roll.second = r_cur.second + 6'd1;
        end else begin
            roll.second = 6'd0;
            if (r_cur.minute != 6'd59) begin
                roll.minute = r_cur.minute + 6'd1;
            end else begin
                roll.minute = 6'd0;
                if (r_cur.hour != 5'd23) begin
                    roll.hour = r_cur.hour + 5'd1;
                end else begin
                    roll.hour = 5'd0;
                    if (r_cur.day < month_len(r_cur.year, r_cur.month)) begin
                        roll.day = r_cur.day + 5'd1;
                    end else begin
                        roll.day = 5'd1;
                        if (r_cur.month != 4'd12) begin
                            roll.month = r_cur.month + 4'd1;
                        end else begin
                            roll.month = 4'd1;
                            roll.year  = r_cur.year + 12'd1;
                        end
                    end
                end
            end
        end
    end

    // ---- datapath next values ----
    always_comb begin
        logic load_out;
        logic err;
        load_out     = 1'b0;
        err          = 1'b0;
        n_tps        = i_cfg_we ? i_cfg_wdata : r_tps;
        n_cur        = r_cur;
        n_sub        = r_sub;
        n_epoch      = r_epoch;
        n_synced     = r_synced;
        n_o_valid    = r_o_valid && !i_ready;
        n_out_date   = r_out_date;
        n_out_sub    = r_out_sub;
        n_out_epoch  = r_out_epoch;
        n_out_synced = r_out_synced;
        n_out_err    = r_out_err;

        if (accept) begin
            case (op)
                OP_TICK: begin
                    load_out = 1'b1;
                    if (wrap) begin
                        n_sub   = 10'd0;
                        n_cur   = roll;
                        n_epoch = ep1;
                    end else begin
                        n_sub = sub_inc[9:0];
                    end
                end
                OP_SET_DATE: begin
                    if (!date_ok) begin
                        load_out = 1'b1;
                        err      = 1'b1;
                    end
                end
                OP_SET_EPOCH: begin
                    if (epoch_bad) begin
                        load_out = 1'b1;
                        err      = 1'b1;
                    end
                end
                default: begin   // read
                    load_out = 1'b1;
                end
            endcase
        end

        if (conv_done) begin
            n_cur    = conv_date;
            n_epoch  = conv_epoch;
            n_sub    = 10'd0;
            n_synced = 1'b1;
            load_out = 1'b1;
        end

        if (load_out) begin
            n_o_valid    = 1'b1;
            n_out_date   = n_cur;
            n_out_sub    = n_sub;
            n_out_epoch  = n_epoch;
            n_out_synced = n_synced;
            n_out_err    = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tps     <= TpsReset;
            r_cur     <= DateReset;
            r_sub     <= 10'd0;
            r_epoch   <= 32'd0;
            r_synced  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tps     <= n_tps;
            r_cur     <= n_cur;
            r_sub     <= n_sub;
            r_epoch   <= n_epoch;
            r_synced  <= n_synced;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_date   <= n_out_date;
        r_out_sub    <= n_out_sub;
        r_out_epoch  <= n_out_epoch;
        r_out_synced <= n_out_synced;
        r_out_err    <= n_out_err;
    end

    ccs_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .i_epoch (i_epoch_in),
        .i_date  (in_date),
        .o_done  (conv_done),
        .o_epoch (conv_epoch),
        .o_date  (conv_date)
    );

    assign o_valid       = r_o_valid;
    assign o_year_out    = r_out_date.year;
    assign o_month_out   = r_out_date.month;
    assign o_day_out     = r_out_date.day;
    assign o_hour_out    = r_out_date.hour;
    assign o_minute_out  = r_out_date.minute;
    assign o_second_out  = r_out_date.second;
    assign o_subtick_out = r_out_sub;
    assign o_epoch_out   = r_out_epoch;
    assign o_synced_out  = r_out_synced;
    assign o_error_out   = r_out_err;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !o_ready)
        else $error("input taken during conversion");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == ST_CONV))
        else $error("conversion finished outside conversion state");

    a_calendar_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.month >= 4'd1) && (r_cur.month <= 4'd12) && (r_cur.hour < 5'd24)
        && (r_cur.minute < 6'd60) && (r_cur.second < 6'd60))
        else $error("calendar state out of range");

endmodule

### tb/ccs_checker.sv
// Checker for the calendar clock: watches both channels, predicts each result
// from its own copy of the calendar state, compares every field. Uses ccs_pkg.
module ccs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_set_year,
    input  logic [3:0]  i_set_month,
    input  logic [4:0]  i_set_day,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    input  logic [5:0]  i_set_second,
    input  logic [31:0] i_epoch_in,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [11:0] o_year_out,
    input  logic [3:0]  o_month_out,
    input  logic [4:0]  o_day_out,
    input  logic [4:0]  o_hour_out,
    input  logic [5:0]  o_minute_out,
    input  logic [5:0]  o_second_out,
    input  logic [9:0]  o_subtick_out,
    input  logic [31:0] o_epoch_out,
    input  logic        o_synced_out,
    input  logic        o_error_out,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ccs_pkg::*;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  subtick;
        logic [31:0] epoch;
        logic        synced;
        logic        error;
    } t_clock_view;

    t_clock_view time_q[$];
    t_clock_view cal;
    logic [9:0]  rate_reg;

    assign o_pending = time_q.size();

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) return 29;
        return tbl[(m - 1) % 12];
    endfunction

    function automatic logic [31:0] date_seconds(int unsigned y, int unsigned mo,
            int unsigned d, int unsigned h, int unsigned mi, int unsigned s);
        logic [31:0] days;
        days = 0;
        for (int unsigned k = 1970; k < y; k++) days += leap_year(k) ? 366 : 365;
        for (int unsigned k = 1; k < mo; k++) days += days_in_month(y, k);
        days += d - 1;
        return days * 32'd86400 + h * 3600 + mi * 60 + s;
    endfunction

    function automatic void load_seconds(ref t_clock_view c, input logic [31:0] e);
        int unsigned days, rem, y, m;
        days = e / 86400;
        rem  = e % 86400;
        y = 1970;
        m = 1;
        while (days >= (leap_year(y) ? 366 : 365)) begin
            days -= leap_year(y) ? 366 : 365;
            y++;
        end
        while (m < 12 && days >= days_in_month(y, m)) begin
            days -= days_in_month(y, m);
            m++;
        end
        c.year = 12'(y);
        c.month = 4'(m);
        c.day = 5'(days + 1);
        c.hour = 5'(rem / 3600);
        c.minute = 6'((rem % 3600) / 60);
        c.second = 6'(rem % 60);
        c.epoch = e;
    endfunction

    function automatic void advance_second(ref t_clock_view c);
        c.epoch = c.epoch + 32'd1;
        if (c.epoch == 0) begin
            load_seconds(c, 0);
            return;
        end
        if (c.second + 1 < 60) begin c.second++; return; end
        c.second = 0;
        if (c.minute + 1 < 60) begin c.minute++; return; end
        c.minute = 0;
        if (c.hour + 1 < 24) begin c.hour++; return; end
        c.hour = 0;
        if (c.day + 1 <= days_in_month(c.year, c.month)) begin c.day++; return; end
        c.day = 1;
        if (c.month + 1 <= 12) begin c.month++; return; end
        c.month = 1;
        c.year = c.year + 12'd1;
    endfunction

    function automatic void apply_item(ref t_clock_view c);
        int unsigned rate, y, mo, d;
        c.error = 0;
        case (t_opcode'(i_opcode))
            OP_TICK: begin
                rate = (rate_reg == 0) ? 1 : rate_reg;
                if (c.subtick + 1 >= rate) begin
                    c.subtick = 0;
                    advance_second(c);
                end else begin
                    c.subtick++;
                end
            end
            OP_SET_DATE: begin
                y = i_set_year;
                mo = i_set_month;
                d = i_set_day;
                if (y < 1970 || y > 2105 || mo < 1 || mo > 12 || i_set_hour >= 24 ||
                    i_set_minute >= 60 || i_set_second >= 60 || d < 1 ||
                    d > days_in_month(y, mo)) begin
                    c.error = 1;
                end else begin
                    c.year = 12'(y);
                    c.month = 4'(mo);
                    c.day = 5'(d);
                    c.hour = i_set_hour;
                    c.minute = i_set_minute;
                    c.second = i_set_second;
                    c.epoch = date_seconds(y, mo, d, i_set_hour, i_set_minute,
                                           i_set_second);
                    c.subtick = 0;
                    c.synced = 1;
                end
            end
            OP_SET_EPOCH: begin
                if (i_epoch_in >= EpochLimit) begin
                    c.error = 1;
                end else begin
                    load_seconds(c, i_epoch_in);
                    c.subtick = 0;
                    c.synced = 1;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_clock_view got, want;
        if (!i_rst_n) begin
            cal <= '{year: 1970, month: 1, day: 1, default: '0};
            rate_reg <= TpsReset;
            time_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) rate_reg <= i_cfg_wdata;
            if (i_valid && o_ready) begin
                t_clock_view nxt;
                nxt = cal;
                apply_item(nxt);
                cal <= nxt;
                time_q.push_back(nxt);
            end
            if (o_valid && i_ready) begin
                got = '{o_year_out, o_month_out, o_day_out, o_hour_out, o_minute_out,
                        o_second_out, o_subtick_out, o_epoch_out, o_synced_out,
                        o_error_out};
                if (time_q.size() == 0) begin
                    // result transfer with nothing predicted
                    if (o_fail_count < 10) $display("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = time_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: exp %0d-%0d-%0d %0d:%0d:%0d st%0d ep%0d",
                                      " s%0b e%0b / got %0d-%0d-%0d %0d:%0d:%0d st%0d",
                                      " ep%0d s%0b e%0b"},
                                want.year, want.month, want.day, want.hour, want.minute,
                                want.second, want.subtick, want.epoch, want.synced,
                                want.error, got.year, got.month, got.day, got.hour,
                                got.minute, got.second, got.subtick, got.epoch,
                                got.synced, got.error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/tb_calendar_clock_with_epoch_sync_top.sv
// Testbench top for the calendar clock: clock, reset, stimulus and verdict.
// Depends on ccs_pkg, calendar_clock_with_epoch_sync_top and ccs_checker.
module tb_calendar_clock_with_epoch_sync_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ccs_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_opcode = OP_READ;
    logic [11:0] i_set_year = '0;
    logic [3:0]  i_set_month = '0;
    logic [4:0]  i_set_day = '0;
    logic [4:0]  i_set_hour = '0;
    logic [5:0]  i_set_minute = '0;
    logic [5:0]  i_set_second = '0;
    logic [31:0] i_epoch_in = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [11:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [9:0]  o_subtick_out;
    logic [31:0] o_epoch_out;
    logic        o_synced_out;
    logic        o_error_out;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    // Worst case: ~1400 items, each a full conversion plus stalls; limit taken well above
    localparam int CycleLimit = 4_000_000;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    calendar_clock_with_epoch_sync_top i_dut (.*);

    ccs_checker u_checker (
        .o_fail_count(fail_count), .o_pending(pending), .*
    );

    // Receiver: stall pattern alternates between long-ready stretches and
    // random back-pressure.
    always @(posedge i_clk) begin
        int phase;
        phase = (cycle_count / 512) % 3;
        if (phase == 0) i_ready <= 1'b1;
        else if (phase == 1) i_ready <= ($urandom_range(0, 3) != 0);
        else i_ready <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One transfer on the input channel; valid held until o_ready.
    task automatic send_item(input t_opcode op, input logic [11:0] y, input logic [3:0] mo,
                             input logic [4:0] d, input logic [4:0] h,
                             input logic [5:0] mi, input logic [5:0] s,
                             input logic [31:0] e);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_set_year <= y;
        i_set_month <= mo;
        i_set_day <= d;
        i_set_hour <= h;
        i_set_minute <= mi;
        i_set_second <= s;
        i_epoch_in <= e;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Gap between bursts; drops valid only when a gap actually happens.
    int burst_left = 0;
    task automatic maybe_idle();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_date(input logic [11:0] y, input logic [3:0] mo, input logic [4:0] d,
                             input logic [4:0] h, input logic [5:0] mi,
                             input logic [5:0] s);
        send_item(OP_SET_DATE, y, mo, d, h, mi, s, $urandom);
        maybe_idle();
    endtask

    task automatic send_simple(input t_opcode op, input logic [31:0] e);
        send_item(op, 12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                  6'($urandom), 6'($urandom), e);
        maybe_idle();
    endtask

    // Drain all predictions, allow the converter time to settle, then write the new rate.
    task automatic drain_then_config(input logic [9:0] rate);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random item: ticks, set-date (mostly valid dates, with a share of broken fields), set-epoch and reads.
    task automatic random_item();
        int sel;
        int unsigned y, mo, d;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            send_simple(OP_TICK, $urandom);
        end else if (sel < 65) begin
            y = $urandom_range(1970, 2105);
            mo = $urandom_range(1, 12);
            d = $urandom_range(1, 31);
            if ($urandom_range(0, 9) == 0) begin
                send_date(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                          6'($urandom), 6'($urandom));
            end else begin
                if (d > 28 && $urandom_range(0, 1)) d = 28;
                send_date(12'(y), 4'(mo), 5'(d), 5'($urandom_range(0, 23)),
                          6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
            end
        end else if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: send_simple(OP_SET_EPOCH, $urandom);
                1: send_simple(OP_SET_EPOCH, EpochLimit - $urandom_range(1, 400));
                2: send_simple(OP_SET_EPOCH, $urandom_range(0, 32'd4291747199));
                default: send_simple(OP_SET_EPOCH, 32'hFFFF_FFFF - $urandom_range(0, 300));
            endcase
        end else begin
            send_simple(OP_READ, $urandom);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, ticks before sync, field extremes
        send_simple(OP_READ, '0);
        repeat (3) send_simple(OP_TICK, '0);
        send_date(12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        send_date(12'd2105, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(12'd2106, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        send_date(12'd1969, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0);
        send_date(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
        send_date(12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);   // century leap
        send_date(12'd2100, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);   // century non-leap
        send_date(12'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0);
        send_date(12'd2023, 4'd0, 5'd0, 5'd24, 6'd60, 6'd60);
        send_simple(OP_SET_EPOCH, EpochLimit);
        send_simple(OP_SET_EPOCH, EpochLimit - 1);
        send_simple(OP_SET_EPOCH, 32'hFFFF_FFFF);
        send_simple(OP_SET_EPOCH, 32'd951782399);               // day before a leap day
        send_simple(OP_SET_EPOCH, '0);

        // one tick per second; walk across year end, 1999 into 2000 and 2105 into 2106
        drain_then_config(10'd1);
        send_date(12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        repeat (2) send_simple(OP_TICK, '0);
        send_date(12'd2105, 4'd12, 5'd31, 5'd23, 6'd59, 6'd58);
        repeat (3) send_simple(OP_TICK, '0);

        // raise then lower the rate mid-second, including zero rate
        drain_then_config(10'd1000);
        repeat (300) random_item();
        drain_then_config(10'd0);
        repeat (250) random_item();
        drain_then_config(10'd3);
        repeat (300) random_item();
        drain_then_config(10'd2);
        repeat (250) random_item();
        drain_then_config(10'd1023);
        repeat (200) random_item();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_conv.sv
hw/rtl/calendar_clock_with_epoch_sync_top.sv
tb/ccs_checker.sv
tb/tb_calendar_clock_with_epoch_sync_top.sv
